>>> src/flvtd_pkg.sv
// Package for the FLV tag demultiplexer: parse phases, tag constants and the
// record passed from the parser to the output stage. No dependencies.
package flvtd_pkg;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0]  KIND_AUDIO   = 8'd8;
    localparam logic [7:0]  KIND_VIDEO   = 8'd9;
    localparam logic [7:0]  KIND_SCRIPT  = 8'd18;
    localparam logic [31:0] FILE_HDR_LEN = 32'd9;
    localparam logic [31:0] TAG_HDR_LEN  = 32'd11;
    localparam logic [31:0] PREV_LEN     = 32'd4;
    localparam logic [3:0]  AAC_FORMAT   = 4'd10;

    localparam logic CH_AUDIO = 1'b0;
    localparam logic CH_VIDEO = 1'b1;

    typedef enum logic [2:0] {
        PH_FILEHDR = 3'd0,
        PH_SKIP    = 3'd1,
        PH_PREV    = 3'd2,
        PH_TAGHDR  = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic        channel;
        logic [7:0]  payload_byte;
        logic        last_of_tag;
        logic [23:0] tag_time;
        logic [23:0] tag_length;
        logic [15:0] audio_info;
        logic [7:0]  video_info;
    } t_rec;

endpackage

>>> src/flv_tag_demuxer_unit.sv
// FLV tag demultiplexer: file bytes in, audio/video payload out.
// A forwarded byte is written into the record queue and then into the output
// register. Throughput: one byte per cycle, set by the parser, while the queue is
// not full; the four-entry queue absorbs output stalls before input is held.
// Reset (synchronous, active low) clears parser phase, queue and output valid.
// Depends on flvtd_pkg, flvtd_front, flvtd_queue, flvtd_back.
module flv_tag_demuxer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [31:8] tag_time, [55:32] tag_length,
    // [59:56] audio_format, [61:60] audio_rate, [62] audio_sample_size,
    // [63] audio_stereo, [71:64] aac_kind, [75:72] video_frame_kind,
    // [79:76] video_codec
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] channel
    output logic        m_axis_tlast    // last_of_tag
);

    logic            fire;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    flvtd_pkg::t_rec rec_in;
    flvtd_pkg::t_rec rec_out;

    assign s_axis_tready = !full;
    assign fire          = s_axis_tvalid && s_axis_tready;

    flvtd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (s_axis_tdata),
        .i_restart (s_axis_tuser),
        .o_push    (push),
        .o_rec     (rec_in)
    );

    flvtd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && fire),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_rec   (rec_out),
        .o_full  (full),
        .o_empty (empty)
    );

    flvtd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_rec     (rec_out),
        .o_pop     (pop),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata),
        .o_channel (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

>>> src/flvtd_front.sv
// Front part: accepts file bytes, tracks the FLV parse phase and emits one
// record per forwarded payload byte. Depends on flvtd_pkg.
module flvtd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    input  logic             i_restart,
    output logic             o_push,
    output flvtd_pkg::t_rec  o_rec
);

    flvtd_pkg::t_phase r_phase, n_phase, e_phase;
    logic [31:0] r_cnt, n_cnt, e_cnt, cnt1;
    logic [31:0] r_hoff, n_hoff, e_hoff;
    logic [7:0]  r_kind, n_kind, e_kind;
    logic [23:0] r_size, n_size, e_size;
    logic [23:0] r_time, n_time, e_time;
    logic [15:0] r_ainfo, n_ainfo, e_ainfo;
    logic [7:0]  r_vinfo, n_vinfo, e_vinfo;
    logic [3:0]  fmt;
    logic        is_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= flvtd_pkg::PH_FILEHDR;
            r_cnt   <= '0;
            r_hoff  <= '0;
            r_kind  <= '0;
            r_size  <= '0;
            r_time  <= '0;
            r_ainfo <= '0;
            r_vinfo <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hoff  <= n_hoff;
            r_kind  <= n_kind;
            r_size  <= n_size;
            r_time  <= n_time;
            r_ainfo <= n_ainfo;
            r_vinfo <= n_vinfo;
        end
    end

    always_comb begin
        if (i_restart) begin
            e_phase = flvtd_pkg::PH_FILEHDR;
            e_cnt   = '0;
            e_hoff  = '0;
            e_kind  = '0;
            e_size  = '0;
            e_time  = '0;
            e_ainfo = '0;
            e_vinfo = '0;
        end else begin
            e_phase = r_phase;
            e_cnt   = r_cnt;
            e_hoff  = r_hoff;
            e_kind  = r_kind;
            e_size  = r_size;
            e_time  = r_time;
            e_ainfo = r_ainfo;
            e_vinfo = r_vinfo;
        end

        n_phase  = e_phase;
        n_hoff   = e_hoff;
        n_kind   = e_kind;
        n_size   = e_size;
        n_time   = e_time;
        n_ainfo  = e_ainfo;
        n_vinfo  = e_vinfo;
        cnt1     = e_cnt + 32'd1;
        n_cnt    = cnt1;
        fmt      = e_ainfo[7:4];
        is_first = (e_cnt == 32'd0);
        o_push   = 1'b0;

        o_rec.channel      = flvtd_pkg::CH_AUDIO;
        o_rec.payload_byte = i_byte;
        o_rec.last_of_tag  = (cnt1 == {8'd0, e_size});
        o_rec.tag_time     = e_time;
        o_rec.tag_length   = e_size;
        o_rec.audio_info   = e_ainfo;
        o_rec.video_info   = e_vinfo;

        unique case (e_phase)
            flvtd_pkg::PH_FILEHDR: begin
                if (e_cnt >= 32'd5) begin
                    n_hoff = {e_hoff[23:0], i_byte};
                end
                if (cnt1 >= flvtd_pkg::FILE_HDR_LEN) begin
                    if (n_hoff <= flvtd_pkg::FILE_HDR_LEN) begin
                        n_phase = flvtd_pkg::PH_PREV;
                        n_cnt   = '0;
                    end else begin
                        n_phase = flvtd_pkg::PH_SKIP;
                    end
                end
            end
            flvtd_pkg::PH_SKIP: begin
                if (cnt1 >= e_hoff) begin
                    n_phase = flvtd_pkg::PH_PREV;
                    n_cnt   = '0;
                end
            end
            flvtd_pkg::PH_PREV: begin
                if (cnt1 >= flvtd_pkg::PREV_LEN) begin
                    n_phase = flvtd_pkg::PH_TAGHDR;
                    n_cnt   = '0;
                end
            end
            flvtd_pkg::PH_TAGHDR: begin
                if (is_first) begin
                    n_kind = i_byte;
                    n_size = '0;
                    n_time = '0;
                end else if (e_cnt <= 32'd3) begin
                    n_size = {e_size[15:0], i_byte};
                end else if (e_cnt <= 32'd6) begin
                    n_time = {e_time[15:0], i_byte};
                end
                if (cnt1 >= flvtd_pkg::TAG_HDR_LEN) begin
                    n_ainfo = '0;
                    n_vinfo = '0;
                    n_cnt   = '0;
                    n_phase = (n_size != 24'd0) ? flvtd_pkg::PH_PAYLOAD
                                                : flvtd_pkg::PH_PREV;
                end
            end
            flvtd_pkg::PH_PAYLOAD: begin
                if (e_kind == flvtd_pkg::KIND_AUDIO) begin
                    if (is_first) begin
                        n_ainfo = {8'd0, i_byte};
                    end else if (e_cnt == 32'd1 && fmt == flvtd_pkg::AAC_FORMAT) begin
                        n_ainfo = {i_byte, e_ainfo[7:0]};
                    end else begin
                        o_push = 1'b1;
                    end
                end else if (e_kind == flvtd_pkg::KIND_VIDEO) begin
                    if (is_first) begin
                        n_vinfo = i_byte;
                    end
                    o_rec.channel    = flvtd_pkg::CH_VIDEO;
                    o_rec.video_info = n_vinfo;
                    o_push           = 1'b1;
                end
                if (cnt1 >= {8'd0, e_size}) begin
                    n_phase = flvtd_pkg::PH_PREV;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_phase = flvtd_pkg::PH_FILEHDR;
                n_cnt   = '0;
                n_hoff  = '0;
                n_kind  = '0;
                n_size  = '0;
                n_time  = '0;
                n_ainfo = '0;
                n_vinfo = '0;
            end
        endcase
    end

endmodule

>>> src/flvtd_queue.sv
// Short record queue between parser and output stage.
// Depends on flvtd_pkg for depth and record type.
module flvtd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  flvtd_pkg::t_rec  i_rec,
    input  logic             i_pop,
    output flvtd_pkg::t_rec  o_rec,
    output logic             o_full,
    output logic             o_empty
);

    flvtd_pkg::t_rec r_mem [flvtd_pkg::QDEPTH];
    logic [flvtd_pkg::PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [flvtd_pkg::CNT_W-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == flvtd_pkg::CNT_W'(flvtd_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

>>> src/flvtd_back.sv
// Back part: pops records, decodes audio/video info bytes into fields and
// holds the result in the output register. Depends on flvtd_pkg.
module flvtd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  flvtd_pkg::t_rec  i_rec,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [79:0]      o_data,
    output logic             o_channel,
    output logic             o_last
);

    logic        r_valid;
    logic [79:0] r_data, n_data;
    logic        r_channel;
    logic        r_last;
    logic [3:0]  fmt;
    logic [7:0]  ai;
    logic [7:0]  aac;
    logic [7:0]  aud;
    logic [7:0]  vid;

    assign o_pop     = !i_empty && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_channel = r_channel;
    assign o_last    = r_last;

    always_comb begin
        ai  = i_rec.audio_info[7:0];
        fmt = ai[7:4];
        if (i_rec.channel == flvtd_pkg::CH_VIDEO) begin
            aud = '0;
            aac = '0;
            vid = {i_rec.video_info[3:0], i_rec.video_info[7:4]};
        end else begin
            aud = {ai[0], ai[1], ai[3:2], fmt};
            aac = (fmt == flvtd_pkg::AAC_FORMAT) ? i_rec.audio_info[15:8] : 8'd0;
            vid = '0;
        end
        n_data = {vid, aac, aud, i_rec.tag_length, i_rec.tag_time, i_rec.payload_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data    <= n_data;
            r_channel <= i_rec.channel;
            r_last    <= i_rec.last_of_tag;
        end
    end

endmodule

>>> verif/flv_tag_demuxer_unit_tb.sv
// Self-checking testbench for flv_tag_demuxer_unit: builds FLV byte streams,
// predicts the forwarded audio/video payload bytes and checks each response.
// Depends on flvtd_pkg and the flv_tag_demuxer_unit RTL.
`timescale 1ns / 100ps

module flv_tag_demuxer_unit_tb;

    typedef struct packed {
        logic [7:0] b;
        logic       rs;
    } t_file_byte;

    typedef struct packed {
        logic        ch;
        logic [7:0]  pb;
        logic        is_last;
        logic [23:0] ttime;
        logic [23:0] tlen;
        logic [3:0]  afmt;
        logic [1:0]  arate;
        logic        asize;
        logic        astereo;
        logic [7:0]  aac;
        logic [3:0]  vframe;
        logic [3:0]  vcodec;
    } t_fwd_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] in_byte
    logic        s_axis_tuser = 1'b0;   // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] payload_byte, [31:8] tag_time, [55:32] tag_length,
    // [59:56] audio_format, [61:60] audio_rate, [62] audio_sample_size,
    // [63] audio_stereo, [71:64] aac_kind, [75:72] video_frame_kind,
    // [79:76] video_codec
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;          // [0] channel
    logic        m_axis_tlast;          // last_of_tag

    t_file_byte  file_bytes[$];
    t_fwd_byte   fwd_expected[$];
    t_fwd_byte   want;
    t_file_byte  next_in;
    int          mismatches = 0;
    int          src_gap = 0;
    int          sink_stall = 0;
    logic        allow_idle = 1'b0;

    // parser state of the prediction
    flvtd_pkg::t_phase ph = flvtd_pkg::PH_FILEHDR;
    logic [31:0] cnt = '0;
    logic [31:0] hdr_off = '0;
    logic [7:0]  kind_now = '0;
    logic [23:0] psize = '0;
    logic [23:0] tstamp = '0;
    logic [15:0] ainfo = '0;
    logic [7:0]  vinfo = '0;

    flv_tag_demuxer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    task automatic demux_byte(input logic [7:0] b, input logic rs);
        t_fwd_byte   r;
        logic [31:0] idx;
        logic [3:0]  fmt;
        if (rs) begin
            ph = flvtd_pkg::PH_FILEHDR;
            cnt = '0;
            hdr_off = '0;
            kind_now = '0;
            psize = '0;
            tstamp = '0;
            ainfo = '0;
            vinfo = '0;
        end
        case (ph)
            flvtd_pkg::PH_FILEHDR: begin
                if (cnt == 0)
                    hdr_off = '0;
                if (cnt >= 5)
                    hdr_off = {hdr_off[23:0], b};
                cnt++;
                if (cnt >= flvtd_pkg::FILE_HDR_LEN) begin
                    if (hdr_off <= flvtd_pkg::FILE_HDR_LEN) begin
                        ph = flvtd_pkg::PH_PREV;
                        cnt = '0;
                    end else begin
                        ph = flvtd_pkg::PH_SKIP;
                    end
                end
            end
            flvtd_pkg::PH_SKIP: begin
                cnt++;
                if (cnt >= hdr_off) begin
                    ph = flvtd_pkg::PH_PREV;
                    cnt = '0;
                end
            end
            flvtd_pkg::PH_PREV: begin
                cnt++;
                if (cnt >= flvtd_pkg::PREV_LEN) begin
                    ph = flvtd_pkg::PH_TAGHDR;
                    cnt = '0;
                end
            end
            flvtd_pkg::PH_TAGHDR: begin
                if (cnt == 0) begin
                    kind_now = b;
                    psize = '0;
                    tstamp = '0;
                end else if (cnt <= 3) begin
                    psize = {psize[15:0], b};
                end else if (cnt <= 6) begin
                    tstamp = {tstamp[15:0], b};
                end
                cnt++;
                if (cnt >= flvtd_pkg::TAG_HDR_LEN) begin
                    ainfo = '0;
                    vinfo = '0;
                    cnt = '0;
                    ph = (psize != 0) ? flvtd_pkg::PH_PAYLOAD : flvtd_pkg::PH_PREV;
                end
            end
            flvtd_pkg::PH_PAYLOAD: begin
                idx = cnt;
                fmt = ainfo[7:4];
                r = '0;
                r.pb = b;
                r.is_last = (idx + 1 == {8'd0, psize});
                r.ttime = tstamp;
                r.tlen = psize;
                if (kind_now == flvtd_pkg::KIND_AUDIO) begin
                    if (idx == 0) begin
                        ainfo = {8'd0, b};
                    end else if (idx == 1 && fmt == flvtd_pkg::AAC_FORMAT) begin
                        ainfo[15:8] = b;
                    end else begin
                        r.ch = flvtd_pkg::CH_AUDIO;
                        r.afmt = fmt;
                        r.arate = ainfo[3:2];
                        r.asize = ainfo[1];
                        r.astereo = ainfo[0];
                        r.aac = (fmt == flvtd_pkg::AAC_FORMAT) ? ainfo[15:8] : 8'd0;
                        fwd_expected.push_back(r);
                    end
                end else if (kind_now == flvtd_pkg::KIND_VIDEO) begin
                    if (idx == 0)
                        vinfo = b;
                    r.ch = flvtd_pkg::CH_VIDEO;
                    r.vframe = vinfo[7:4];
                    r.vcodec = vinfo[3:0];
                    fwd_expected.push_back(r);
                end
                cnt++;
                if (cnt >= {8'd0, psize}) begin
                    ph = flvtd_pkg::PH_PREV;
                    cnt = '0;
                end
            end
            default: ph = flvtd_pkg::PH_FILEHDR;
        endcase
    endtask

    function automatic void check_field(input string fname, input logic [23:0] exp_v,
                                        input logic [23:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, fname, exp_v, act_v);
        end
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic rs = 1'b0);
        t_file_byte fb;
        fb.b = b;
        fb.rs = rs;
        file_bytes.push_back(fb);
    endtask

    task automatic add_file_header(input logic [31:0] off);
        int i;
        add_byte(8'h46, 1'b1);
        add_byte(8'h4C);
        add_byte(8'h56);
        add_byte(8'h01);
        add_byte(8'h05);
        for (i = 0; i < 4; i++)
            add_byte(off[31 - 8 * i -: 8]);
        if (off > flvtd_pkg::FILE_HDR_LEN && off < 64)
            repeat (off - flvtd_pkg::FILE_HDR_LEN) add_byte(8'($urandom));
    endtask

    // lead < 0: random first payload byte; send < plen truncates the tag
    task automatic add_tag(input logic [7:0] kind, input int plen, input int ts,
                           input int lead, input int send);
        int i;
        repeat (4) add_byte(8'($urandom));
        add_byte(kind);
        add_byte(plen[23:16]);
        add_byte(plen[15:8]);
        add_byte(plen[7:0]);
        add_byte(ts[23:16]);
        add_byte(ts[15:8]);
        add_byte(ts[7:0]);
        repeat (4) add_byte(8'($urandom));
        for (i = 0; i < send; i++) begin
            if (i == 0 && lead >= 0)
                add_byte(lead[7:0]);
            else
                add_byte(8'($urandom));
        end
    endtask

    // driver: hold a request until accepted, insert random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            allow_idle <= file_bytes.size() > 80 && (file_bytes.size() / 50) % 3 != 0;
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (file_bytes.size() > 0) begin
                    next_in = file_bytes.pop_front();
                    s_axis_tdata <= next_in.b;
                    s_axis_tuser <= next_in.rs;
                    s_axis_tvalid <= 1'b1;
                    if (allow_idle && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 15);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (allow_idle && $urandom_range(0, 5) == 0)
                sink_stall = $urandom_range(1, 15);
        end
    end

    // monitor: predict on each accepted request, check each forwarded byte
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                demux_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                if (fwd_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected output, expected none, actual tdata 0x%0h",
                             $time, m_axis_tdata);
                end else begin
                    want = fwd_expected.pop_front();
                    check_field("channel", want.ch, m_axis_tuser);
                    check_field("payload_byte", want.pb, m_axis_tdata[7:0]);
                    check_field("last_of_tag", want.is_last, m_axis_tlast);
                    check_field("tag_time", want.ttime, m_axis_tdata[31:8]);
                    check_field("tag_length", want.tlen, m_axis_tdata[55:32]);
                    check_field("audio_format", want.afmt, m_axis_tdata[59:56]);
                    check_field("audio_rate", want.arate, m_axis_tdata[61:60]);
                    check_field("audio_sample_size", want.asize, m_axis_tdata[62]);
                    check_field("audio_stereo", want.astereo, m_axis_tdata[63]);
                    check_field("aac_kind", want.aac, m_axis_tdata[71:64]);
                    check_field("video_frame_kind", want.vframe, m_axis_tdata[75:72]);
                    check_field("video_codec", want.vcodec, m_axis_tdata[79:76]);
                end
            end
        end
    end

    initial begin
        int          n_tags;
        int          t;
        int          pick;
        int          plen;
        int          send;
        int          lead;
        logic [31:0] off;
        logic [7:0]  kind;

        add_file_header(32'd9);
        add_tag(flvtd_pkg::KIND_AUDIO, 4, 0, 8'h3F, 4);
        add_tag(flvtd_pkg::KIND_AUDIO, 5, 24'hFFFFFF, 8'hAF, 5);
        add_tag(flvtd_pkg::KIND_AUDIO, 4, 24'h123456, 8'h00, 4);
        add_tag(flvtd_pkg::KIND_VIDEO, 3, 24'h000001, 8'hFF, 3);
        add_tag(flvtd_pkg::KIND_VIDEO, 1, 24'h800000, 8'h00, 1);
        add_tag(flvtd_pkg::KIND_SCRIPT, 3, 24'h000100, -1, 3);
        add_tag(flvtd_pkg::KIND_AUDIO | 8'h20, 2, 24'h000200, -1, 2);
        add_tag(8'hFF, 1, 24'h000300, -1, 1);
        add_tag(flvtd_pkg::KIND_VIDEO, 0, 24'h000400, -1, 0);
        add_tag(flvtd_pkg::KIND_AUDIO, 1, 24'h000500, 8'h12, 1);
        add_tag(flvtd_pkg::KIND_AUDIO, 2, 24'h000600, 8'hA3, 2);
        add_tag(flvtd_pkg::KIND_AUDIO, 1, 24'h000700, 8'hA5, 1);
        add_tag(flvtd_pkg::KIND_VIDEO, 24'hFFFFFF, 24'h7FFFFF, 8'h17, 6);
        add_file_header(32'd0);
        add_tag(flvtd_pkg::KIND_AUDIO, 3, 24'h00ABCD, 8'h5A, 3);
        add_file_header(32'd13);
        add_tag(flvtd_pkg::KIND_VIDEO, 2, 24'h0F0F0F, 8'h27, 2);
        add_file_header(32'hFFFF_FFFF);
        repeat (6) add_byte(8'($urandom));
        add_byte(8'h46, 1'b1);
        add_byte(8'h4C);
        add_byte(8'h56);
        add_file_header(32'd10);
        add_tag(flvtd_pkg::KIND_VIDEO, 2, 24'hF0F0F0, 8'h12, 2);
        add_tag(flvtd_pkg::KIND_AUDIO, 8, 24'h555555, 8'hA1, 3);

        while (file_bytes.size() < 450) begin
            if ($urandom_range(0, 9) < 8) begin
                case ($urandom_range(0, 3))
                    0:       off = $urandom_range(0, 9);
                    1:       off = flvtd_pkg::FILE_HDR_LEN;
                    default: off = $urandom_range(10, 20);
                endcase
                add_file_header(off);
                n_tags = $urandom_range(1, 5);
                for (t = 0; t < n_tags; t++) begin
                    pick = $urandom_range(0, 9);
                    lead = -1;
                    if (pick < 4) begin
                        kind = flvtd_pkg::KIND_AUDIO;
                        lead = ($urandom_range(0, 1) == 0)
                             ? int'({flvtd_pkg::AAC_FORMAT, 4'($urandom)})
                             : int'($urandom_range(0, 255));
                    end else if (pick < 8) begin
                        kind = flvtd_pkg::KIND_VIDEO;
                    end else if (pick == 8) begin
                        kind = flvtd_pkg::KIND_SCRIPT;
                    end else begin
                        kind = 8'($urandom);
                    end
                    plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                       : $urandom_range(3, 12);
                    send = plen;
                    if (t == n_tags - 1 && $urandom_range(0, 7) == 0)
                        send = $urandom_range(0, plen);
                    add_tag(kind, plen, int'($urandom_range(0, 24'hFFFFFF)), lead, send);
                end
            end else begin
                repeat ($urandom_range(5, 30))
                    add_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (file_bytes.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (fwd_expected.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
